// File: hw/rtl/sobel_pkg.sv
`default_nettype none

package sobel_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MIN_DIM    = 3;

    localparam int PIX_W  = 8;
    localparam int DIM_W  = 9;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    localparam logic [DIM_W-1:0] RESET_WIDTH  = 9'd32;
    localparam logic [DIM_W-1:0] RESET_HEIGHT = 9'd32;

    localparam logic [PIX_W-1:0] EDGE_MAX = 8'd255;

    typedef logic [PIX_W-1:0] t_pixel;

    // The eight neighbours of a 3x3 window; the middle pixel has zero weight and is not held.
    typedef struct packed {
        t_pixel tl;
        t_pixel tc;
        t_pixel tr;
        t_pixel ml;
        t_pixel mr;
        t_pixel bl;
        t_pixel bc;
        t_pixel br;
    } t_window;

endpackage

`default_nettype wire

// File: hw/rtl/sobel_kernel.sv
`default_nettype none

module sobel_kernel (
    input  var sobel_pkg::t_window i_win,
    output logic [sobel_pkg::PIX_W-1:0] o_edge_value
);

    logic [9:0]         w_left;
    logic [9:0]         w_right;
    logic [9:0]         w_upper;
    logic [9:0]         w_lower;
    logic signed [10:0] w_gx;
    logic signed [10:0] w_gy;
    logic [9:0]         w_abs_x;
    logic [9:0]         w_abs_y;
    logic [10:0]        w_sum;
    logic [8:0]         w_scaled;

    always_comb begin
        w_left  = {2'b00, i_win.tl} + {3'b000, i_win.ml[7:1]} + {2'b00, i_win.bl};
        w_right = {2'b00, i_win.tr} + {3'b000, i_win.mr[7:1]} + {2'b00, i_win.br};
        w_upper = {2'b00, i_win.tl} + {3'b000, i_win.tc[7:1]} + {2'b00, i_win.tr};
        w_lower = {2'b00, i_win.bl} + {3'b000, i_win.bc[7:1]} + {2'b00, i_win.br};
        w_gx    = signed'({1'b0, w_left})  - signed'({1'b0, w_right});
        w_gy    = signed'({1'b0, w_upper}) - signed'({1'b0, w_lower});
        // Each column or row sum is at most 637, so ten bits hold the magnitude.
        w_abs_x = w_gx[10] ? 10'(-w_gx) : 10'(w_gx);
        w_abs_y = w_gy[10] ? 10'(-w_gy) : 10'(w_gy);
        w_sum    = {1'b0, w_abs_x} + {1'b0, w_abs_y};
        w_scaled = w_sum[10:2];
        o_edge_value = w_scaled[8] ? sobel_pkg::EDGE_MAX : w_scaled[7:0];
    end

endmodule

`default_nettype wire

// File: hw/rtl/sobel_edge_magnitude_3x3.sv
// Channel   Direction  Handshake                   Payload
// input     in         i_in_valid / o_in_ready     i_pixel
// result    out        o_out_valid / i_out_ready   o_edge_value, o_last_of_frame
// config    in         i_cfg_we (no wait)          i_cfg_index, i_cfg_data
//
// One pixel per clock is accepted while o_in_ready is high. The line store is
// read at acceptance into the stage-one registers; the edge then goes to the
// result register. Reset clears counters, window and handshake state and loads
// the reset sizes; line stores are not cleared. A stalled result holds its stage,
// and the input stalls only when both stages are full.
`default_nettype none

module sobel_edge_magnitude_3x3 (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [sobel_pkg::PIX_W-1:0]           i_pixel,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [sobel_pkg::PIX_W-1:0]           o_edge_value,
    output logic                                  o_last_of_frame,
    input  logic                                  i_cfg_we,
    input  logic [sobel_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sobel_pkg::DIM_W-1:0]           i_cfg_data
);

    localparam int PW = sobel_pkg::PIX_W;
    localparam int DW = sobel_pkg::DIM_W;
    localparam int CW = sobel_pkg::COL_W;
    localparam int RW = sobel_pkg::ROW_W;

    logic [DW-1:0] r_image_width;
    logic [DW-1:0] r_image_height;

    logic [PW-1:0] r_line_upper [sobel_pkg::MAX_WIDTH];
    logic [PW-1:0] r_line_middle [sobel_pkg::MAX_WIDTH];

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;

    // Window columns to the left: index 0..2 older column, 3..5 newer column.
    logic [PW-1:0] r_win [6];

    logic          r_s1_valid;
    logic          r_s1_produce;
    logic          r_s1_last;
    logic [CW-1:0] r_s1_col;
    logic [PW-1:0] r_s1_top;
    logic [PW-1:0] r_s1_mid;
    logic [PW-1:0] r_s1_bot;

    logic          r_out_valid;
    logic [PW-1:0] r_out_edge;
    logic          r_out_last;

    logic [DW-1:0] w_width;
    logic [DW-1:0] w_height;
    logic [DW-1:0] w_row_wrap;
    logic [DW-1:0] w_col_plus;
    logic [DW-1:0] w_row_plus;
    logic [CW-1:0] w_cur_col;
    logic [RW-1:0] w_cur_row;
    logic          w_produce;
    logic          w_last;
    logic          w_s1_advance;
    logic          w_accept;

    sobel_pkg::t_window w_window;
    logic [PW-1:0]      w_edge;

    always_comb begin
        if (r_image_width < DW'(sobel_pkg::MIN_DIM)) begin
            w_width = DW'(sobel_pkg::MIN_DIM);
        end else if (r_image_width > DW'(sobel_pkg::MAX_WIDTH)) begin
            w_width = DW'(sobel_pkg::MAX_WIDTH);
        end else begin
            w_width = r_image_width;
        end
        if (r_image_height < DW'(sobel_pkg::MIN_DIM)) begin
            w_height = DW'(sobel_pkg::MIN_DIM);
        end else if (r_image_height > DW'(sobel_pkg::MAX_HEIGHT)) begin
            w_height = DW'(sobel_pkg::MAX_HEIGHT);
        end else begin
            w_height = r_image_height;
        end

        // A shrunk width or height takes effect on the next pixel.
        if ({1'b0, r_col} >= w_width) begin
            w_cur_col  = '0;
            w_row_wrap = {1'b0, r_row} + DW'(1);
        end else begin
            w_cur_col  = r_col;
            w_row_wrap = {1'b0, r_row};
        end
        w_cur_row = (w_row_wrap >= w_height) ? '0 : w_row_wrap[RW-1:0];

        w_produce = (w_cur_row >= RW'(2)) && (w_cur_col >= CW'(2));
        w_last    = ({1'b0, w_cur_row} == w_height - DW'(1))
                 && ({1'b0, w_cur_col} == w_width - DW'(1));

        w_col_plus = {1'b0, w_cur_col} + DW'(1);
        w_row_plus = {1'b0, w_cur_row} + DW'(1);
        if (w_col_plus >= w_width) begin
            n_col = '0;
            n_row = (w_row_plus >= w_height) ? '0 : w_row_plus[RW-1:0];
        end else begin
            n_col = w_col_plus[CW-1:0];
            n_row = w_cur_row;
        end
    end

    assign w_s1_advance = !r_out_valid || i_out_ready;
    assign o_in_ready   = !r_s1_valid || w_s1_advance;
    assign w_accept     = i_in_valid && o_in_ready;

    always_comb begin
        w_window.tl = r_win[0];
        w_window.ml = r_win[1];
        w_window.bl = r_win[2];
        w_window.tc = r_win[3];
        w_window.bc = r_win[5];
        w_window.tr = r_s1_top;
        w_window.mr = r_s1_mid;
        w_window.br = r_s1_bot;
    end

    sobel_kernel u_kernel (
        .i_win        (w_window),
        .o_edge_value (w_edge)
    );

    // Line stores: the middle row moves up one store while the new pixel
    // takes its place. The upper store is written from the stage that holds
    // the middle value read at acceptance.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_top <= r_line_upper[w_cur_col];
            r_s1_mid <= r_line_middle[w_cur_col];
            r_line_middle[w_cur_col] <= i_pixel;
            r_s1_bot     <= i_pixel;
            r_s1_col     <= w_cur_col;
            r_s1_produce <= w_produce;
            r_s1_last    <= w_last;
        end
        if (r_s1_valid) begin
            r_line_upper[r_s1_col] <= r_s1_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= sobel_pkg::RESET_WIDTH;
            r_image_height <= sobel_pkg::RESET_HEIGHT;
            r_col          <= '0;
            r_row          <= '0;
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sobel_pkg::CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                    sobel_pkg::CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (w_s1_advance) begin
                r_out_valid <= r_s1_valid && r_s1_produce;
                if (r_s1_valid) begin
                    r_win[0] <= r_win[3];
                    r_win[1] <= r_win[4];
                    r_win[2] <= r_win[5];
                    r_win[3] <= r_s1_top;
                    r_win[4] <= r_s1_mid;
                    r_win[5] <= r_s1_bot;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_advance && r_s1_valid && r_s1_produce) begin
            r_out_edge <= w_edge;
            r_out_last <= r_s1_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_edge_value    = r_out_edge;
    assign o_last_of_frame = r_out_last;

endmodule

`default_nettype wire

// File: hw/rtl/sobel_chk.sv
`default_nettype none

module sobel_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [sobel_pkg::PIX_W-1:0]   o_edge_value,
    input logic                          o_last_of_frame
);

    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A new result follows an accepted pixel request that passed the stage-one registers.
    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("result appeared without an accepted pixel");

    // A stalled result keeps its payload.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_edge_value) && $stable(o_last_of_frame)))
        else $error("stalled result changed");

    // A frame is at least nine pixels, so two frame ends never follow directly.
    a_frame_end_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last_of_frame) |=>
            !(o_out_valid && o_last_of_frame))
        else $error("frame end repeated on consecutive results");

endmodule

bind sobel_edge_magnitude_3x3 sobel_chk u_sobel_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_edge_value    (o_edge_value),
    .o_last_of_frame (o_last_of_frame)
);

`default_nettype wire

// File: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum bit {STEP_PIXEL, STEP_WRITE} t_step_kind;
    typedef enum {SHAPE_SMALL, SHAPE_WIDE, SHAPE_TALL} t_shape;

    typedef struct packed {
        sobel_pkg::t_pixel value;
        bit                last;
    } t_edge_result;

    typedef struct packed {
        t_step_kind                      kind;
        logic [sobel_pkg::CFG_IDX_W-1:0] index;
        logic [sobel_pkg::DIM_W-1:0]     data;
        sobel_pkg::t_pixel               pix;
        bit                              typed;
        t_edge_result                    want;
    } t_script_row;

    // Directed frames, raster order, first pixel in the top byte.
    localparam logic [71:0] LEFT_EDGE_FRAME = {8'd255, 8'd0, 8'd0,
                                               8'd255, 8'd0, 8'd0,
                                               8'd255, 8'd0, 8'd0};
    localparam logic [71:0] CORNER_FRAME    = {8'd255, 8'd255, 8'd0,
                                               8'd255, 8'd0,   8'd0,
                                               8'd0,   8'd0,   8'd0};

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_ready;
    sobel_pkg::t_pixel               i_pixel = '0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    sobel_pkg::t_pixel               o_edge_value;
    logic                            o_last_of_frame;
    logic                            i_cfg_we = 1'b0;
    logic [sobel_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [sobel_pkg::DIM_W-1:0]     i_cfg_data = '0;

    sobel_edge_magnitude_3x3 uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_pixel         (i_pixel),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_edge_value    (o_edge_value),
        .o_last_of_frame (o_last_of_frame),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Predictor state: line stores, two window columns and the raster position.
    sobel_pkg::t_pixel           upper_row   [sobel_pkg::MAX_WIDTH];
    sobel_pkg::t_pixel           middle_row  [sobel_pkg::MAX_WIDTH];
    bit                          upper_known [sobel_pkg::MAX_WIDTH];
    bit                          middle_known[sobel_pkg::MAX_WIDTH];
    sobel_pkg::t_pixel           left_cols   [6];
    int                          col_pos;
    int                          row_pos;
    logic [sobel_pkg::DIM_W-1:0] width_reg;
    logic [sobel_pkg::DIM_W-1:0] height_reg;

    t_edge_result pending_edges[$];
    t_script_row  script[$];
    int           mismatches = 0;
    int           pixels_sent = 0;
    bit           calm = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(0, 99) >= 31);
    end

    always @(posedge i_clk) begin
        t_edge_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_edges.size() == 0) begin
                $display("%0t: unexpected edge result: expected none, got edge %0d last %0b",
                         $time, o_edge_value, o_last_of_frame);
                mismatches++;
            end else begin
                want = pending_edges.pop_front();
                if (o_edge_value !== want.value) begin
                    $display("%0t: edge_value expected %0d, got %0d",
                             $time, want.value, o_edge_value);
                    mismatches++;
                end
                if (o_last_of_frame !== want.last) begin
                    $display("%0t: last_of_frame expected %0b, got %0b",
                             $time, want.last, o_last_of_frame);
                    mismatches++;
                end
            end
        end
    end

    function automatic int dim_in_force(input logic [sobel_pkg::DIM_W-1:0] v, input int hi);
        if (v < sobel_pkg::MIN_DIM) return sobel_pkg::MIN_DIM;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    // Advances the window by one pixel; returns 1 when a full window yields an edge.
    function automatic bit next_edge(input sobel_pkg::t_pixel pix, output t_edge_result res);
        int                w, h, c, r, gx, gy, mag;
        sobel_pkg::t_pixel top, mid;
        bit                made;
        w = dim_in_force(width_reg, sobel_pkg::MAX_WIDTH);
        h = dim_in_force(height_reg, sobel_pkg::MAX_HEIGHT);
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        c = col_pos;
        r = row_pos;
        top = upper_row[c];
        mid = middle_row[c];
        made = (r >= 2) && (c >= 2);
        res = '0;
        if (made) begin
            gx = int'(left_cols[0]) + int'(left_cols[1] >> 1) + int'(left_cols[2])
                 - (int'(top) + int'(mid >> 1) + int'(pix));
            gy = int'(left_cols[0]) + int'(left_cols[3] >> 1) + int'(top)
                 - (int'(left_cols[2]) + int'(left_cols[5] >> 1) + int'(pix));
            mag = ((gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy)) >> 2;
            if (mag > int'(sobel_pkg::EDGE_MAX)) mag = int'(sobel_pkg::EDGE_MAX);
            res.value = sobel_pkg::t_pixel'(mag);
            res.last = (r == h - 1) && (c == w - 1);
        end
        left_cols[0] = left_cols[3];
        left_cols[1] = left_cols[4];
        left_cols[2] = left_cols[5];
        left_cols[3] = top;
        left_cols[4] = mid;
        left_cols[5] = pix;
        upper_row[c] = mid;
        upper_known[c] = middle_known[c];
        middle_row[c] = pix;
        middle_known[c] = 1'b1;
        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h) row_pos = 0;
        end
        return made;
    endfunction

    // A wider row mid-frame is only allowed when every column it reaches holds real pixels.
    function automatic bit grow_is_safe(input int new_w);
        if (row_pos == 0) return 1'b1;
        for (int c = 0; c < new_w; c++) begin
            if (!(upper_known[c] && middle_known[c])) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int pixels_to_frame_end();
        int w, h, c, r;
        w = dim_in_force(width_reg, sobel_pkg::MAX_WIDTH);
        h = dim_in_force(height_reg, sobel_pkg::MAX_HEIGHT);
        c = col_pos;
        r = row_pos;
        if (c >= w) begin
            c = 0;
            r++;
        end
        if (r >= h) r = 0;
        return (h - 1 - r) * w + (w - c);
    endfunction

    function automatic sobel_pkg::t_pixel random_pixel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return sobel_pkg::t_pixel'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_script_row pix_row(input sobel_pkg::t_pixel pix, input bit typed,
                                            input sobel_pkg::t_pixel value, input bit last);
        t_script_row row;
        row = '0;
        row.kind = STEP_PIXEL;
        row.pix = pix;
        row.typed = typed;
        row.want.value = value;
        row.want.last = last;
        return row;
    endfunction

    function automatic t_script_row write_row(input logic [sobel_pkg::CFG_IDX_W-1:0] index,
                                              input logic [sobel_pkg::DIM_W-1:0] data);
        t_script_row row;
        row = '0;
        row.kind = STEP_WRITE;
        row.index = index;
        row.data = data;
        return row;
    endfunction

    // A pixel request stays up, unchanged, until the block takes it.
    task automatic feed_pixel(input sobel_pkg::t_pixel pix, input bit typed,
                              input t_edge_result typed_res);
        t_edge_result res;
        bit           made;
        while (!calm && $urandom_range(0, 99) < 31) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel <= pix;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        made = next_edge(pix, res);
        if (typed) pending_edges.push_back(typed_res);
        else if (made) pending_edges.push_back(res);
        pixels_sent++;
        calm = (pixels_sent >= 400) && (pixels_sent < 500);
    endtask

    // Lets the block run dry; pixels with no edge may still be in the pipe.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_edges.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [sobel_pkg::CFG_IDX_W-1:0] index,
                             input logic [sobel_pkg::DIM_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == sobel_pkg::CFG_IMAGE_WIDTH) width_reg = data;
        else height_reg = data;
        @(posedge i_clk);
    endtask

    task automatic run_phase(input t_shape shape);
        logic [sobel_pkg::DIM_W-1:0] new_w;
        logic [sobel_pkg::DIM_W-1:0] new_h;
        bit                          set_w;
        bit                          set_h;
        int                          count;
        case (shape)
            SHAPE_WIDE: begin
                case ($urandom_range(0, 2))
                    0: new_w = 9'd256;
                    1: new_w = 9'd257;
                    default: new_w = 9'd511;
                endcase
                new_h = sobel_pkg::DIM_W'($urandom_range(0, 3));
                set_w = 1'b1;
                set_h = 1'b1;
            end
            SHAPE_TALL: begin
                case ($urandom_range(0, 2))
                    0: new_h = 9'd256;
                    1: new_h = 9'd300;
                    default: new_h = 9'd511;
                endcase
                new_w = sobel_pkg::DIM_W'($urandom_range(0, 3));
                set_w = 1'b1;
                set_h = 1'b1;
            end
            default: begin
                set_w = $urandom_range(0, 99) < 60;
                set_h = $urandom_range(0, 99) < 60;
                new_w = ($urandom_range(0, 19) == 0)
                        ? sobel_pkg::DIM_W'($urandom_range(15, 64))
                        : sobel_pkg::DIM_W'($urandom_range(0, 14));
                new_h = ($urandom_range(0, 19) == 0)
                        ? sobel_pkg::DIM_W'($urandom_range(11, 40))
                        : sobel_pkg::DIM_W'($urandom_range(0, 10));
            end
        endcase
        settle();
        if (set_w && !grow_is_safe(dim_in_force(new_w, sobel_pkg::MAX_WIDTH))) begin
            count = pixels_to_frame_end();
            repeat (count) feed_pixel(random_pixel(), 1'b0, '0);
            settle();
        end
        if (set_w) write_reg(sobel_pkg::CFG_IMAGE_WIDTH, new_w);
        if (set_h) write_reg(sobel_pkg::CFG_IMAGE_HEIGHT, new_h);
        count = pixels_to_frame_end();
        if (shape == SHAPE_SMALL) begin
            if ($urandom_range(0, 1)) begin
                if ($urandom_range(0, 1)) begin
                    count += dim_in_force(width_reg, sobel_pkg::MAX_WIDTH)
                             * dim_in_force(height_reg, sobel_pkg::MAX_HEIGHT);
                end
            end else begin
                count = $urandom_range(1, 40);
            end
            if (count > 400) count = 400;
        end
        repeat (count) feed_pixel(random_pixel(), 1'b0, '0);
    endtask

    initial begin
        t_script_row row;
        t_shape      shape;
        int          phase;

        width_reg = sobel_pkg::RESET_WIDTH;
        height_reg = sobel_pkg::RESET_HEIGHT;
        col_pos = 0;
        row_pos = 0;
        for (int i = 0; i < 6; i++) left_cols[i] = '0;
        for (int i = 0; i < sobel_pkg::MAX_WIDTH; i++) begin
            upper_row[i] = '0;
            middle_row[i] = '0;
            upper_known[i] = 1'b0;
            middle_known[i] = 1'b0;
        end

        // Dimensions below the minimum act as 3. A left column of 255 gives
        // gx = 255 + 127 + 255, gy = 0; a bright top-left corner gives 382 on both.
        script.push_back(write_row(sobel_pkg::CFG_IMAGE_WIDTH, 9'd0));
        script.push_back(write_row(sobel_pkg::CFG_IMAGE_HEIGHT, 9'd1));
        for (int i = 0; i < 9; i++) begin
            script.push_back(pix_row(LEFT_EDGE_FRAME[8 * (8 - i) +: 8], i == 8, 8'd159, 1'b1));
        end
        script.push_back(write_row(sobel_pkg::CFG_IMAGE_WIDTH, 9'd2));
        script.push_back(write_row(sobel_pkg::CFG_IMAGE_HEIGHT, 9'd3));
        for (int i = 0; i < 9; i++) begin
            script.push_back(pix_row(CORNER_FRAME[8 * (8 - i) +: 8], i == 8, 8'd191, 1'b1));
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) begin
            row = script[i];
            if (row.kind == STEP_WRITE) begin
                settle();
                write_reg(row.index, row.data);
            end else begin
                feed_pixel(row.pix, row.typed, row.want);
            end
        end

        // A small frame first, then one large frame, either full width or full height, then small frames.
        phase = 0;
        while (pixels_sent < 800) begin
            if (phase == 1) begin
                if ($urandom_range(0, 1) == 0) shape = SHAPE_WIDE;
                else shape = SHAPE_TALL;
            end else begin
                shape = SHAPE_SMALL;
            end
            run_phase(shape);
            phase++;
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_edges.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
